// ----- src/msu_pkg.sv -----
// msu_pkg: shared codes and types for the merge sorter unit
// no dependencies; imported by the merge engine and the top level

package msu_pkg;

    // request command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // result status codes
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_EMPTY = 1'b1;

    // merge engine status toward the top level
    typedef struct packed {
        logic busy;
        logic pass_done;
        logic done;
    } t_merge_stat;

endpackage

// ----- src/msu_if.sv -----
// msu_if: request and result channel interfaces of the merge sorter unit
// no dependencies; used by the top level ports

interface msu_in_if #(
    parameter int VALUE_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface msu_out_if #(
    parameter int VALUE_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] sorted_value;
    logic                  is_last;
    logic                  status;

    modport source (output valid, output sorted_value, output is_last, output status,
                    input ready);
    modport sink   (input valid, input sorted_value, input is_last, input status,
                    output ready);
endinterface

// ----- src/msu_store.sv -----
// msu_store: two value memories, one write port and two registered read ports
// no dependencies; instantiated by merge_sorter_unit

module msu_store #(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 8,
    parameter int AW         = 8
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic                  i_wr_sel,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [VALUE_BITS-1:0] i_wr_data,
    input  logic                  i_rd_sel,
    input  logic [AW-1:0]         i_rd_a_addr,
    input  logic [AW-1:0]         i_rd_b_addr,
    output logic [VALUE_BITS-1:0] o_rd_a_data,
    output logic [VALUE_BITS-1:0] o_rd_b_data
);

    logic [VALUE_BITS-1:0] r_mem0 [CAPACITY];
    logic [VALUE_BITS-1:0] r_mem1 [CAPACITY];

    logic [VALUE_BITS-1:0] r_a0, r_a1, r_b0, r_b1;
    logic                  r_sel;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && !i_wr_sel) begin
            r_mem0[i_wr_addr] <= i_wr_data;
        end
        r_a0 <= r_mem0[i_rd_a_addr];
        r_b0 <= r_mem0[i_rd_b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_sel) begin
            r_mem1[i_wr_addr] <= i_wr_data;
        end
        r_a1 <= r_mem1[i_rd_a_addr];
        r_b1 <= r_mem1[i_rd_b_addr];
    end

    always_ff @(posedge i_clk) begin
        r_sel <= i_rd_sel;
    end

    assign o_rd_a_data = r_sel ? r_a1 : r_a0;
    assign o_rd_b_data = r_sel ? r_b1 : r_b0;

endmodule

// ----- src/msu_merge.sv -----
// msu_merge: bottom-up merge pass sequencer; each output element takes a read step and a compare-and-write step
// depends on msu_pkg; drives the read and write ports of msu_store

module msu_merge #(
    parameter int VALUE_BITS = 8,
    parameter int AW         = 8,
    parameter int NW         = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NW-1:0]         i_count,
    input  logic [VALUE_BITS-1:0] i_rd_a_data,
    input  logic [VALUE_BITS-1:0] i_rd_b_data,
    output logic [AW-1:0]         o_rd_a_addr,
    output logic [AW-1:0]         o_rd_b_addr,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [VALUE_BITS-1:0] o_wr_data,
    output msu_pkg::t_merge_stat  o_stat
);

    import msu_pkg::*;

    typedef enum logic [1:0] {
        M_IDLE,
        M_RUN,
        M_RD,
        M_CMP
    } t_mstate;

    t_mstate       r_state;
    logic [NW-1:0] r_n, r_lo, r_mid, r_hi, r_a, r_b, r_wr;
    logic [NW:0]   r_width;

    logic [NW+1:0] w_mid_sum, w_hi_sum, w_n_ext;
    logic [NW-1:0] w_mid, w_hi, w_wr_inc;
    logic [NW:0]   w_width2;
    logic          w_take_a, w_run_end, w_pass_end, w_all_done;

    // run bounds, clipped to the set size
    always_comb begin
        w_n_ext   = (NW+2)'(r_n);
        w_mid_sum = (NW+2)'(r_lo) + (NW+2)'(r_width);
        w_hi_sum  = w_mid_sum + (NW+2)'(r_width);
        w_mid     = (w_mid_sum > w_n_ext) ? r_n : w_mid_sum[NW-1:0];
        w_hi      = (w_hi_sum > w_n_ext) ? r_n : w_hi_sum[NW-1:0];
    end

    // left run wins ties
    always_comb begin
        w_take_a   = (r_a < r_mid) && ((r_b >= r_hi) || (i_rd_a_data <= i_rd_b_data));
        w_wr_inc   = r_wr + NW'(1);
        w_run_end  = (w_wr_inc == r_hi);
        w_pass_end = w_run_end && (r_hi == r_n);
        w_width2   = {r_width[NW-1:0], 1'b0};
        w_all_done = w_pass_end && (w_width2 >= {1'b0, r_n});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_n     <= i_count;
                        r_width <= (NW+1)'(1);
                        r_lo    <= '0;
                        r_state <= M_RUN;
                    end
                end
                M_RUN: begin
                    r_a     <= r_lo;
                    r_b     <= w_mid;
                    r_mid   <= w_mid;
                    r_hi    <= w_hi;
                    r_wr    <= r_lo;
                    r_state <= M_RD;
                end
                M_RD: begin
                    r_state <= M_CMP;
                end
                M_CMP: begin
                    r_wr <= w_wr_inc;
                    if (w_take_a) begin
                        r_a <= r_a + NW'(1);
                    end else begin
                        r_b <= r_b + NW'(1);
                    end
                    if (w_all_done) begin
                        r_state <= M_IDLE;
                    end else if (w_pass_end) begin
                        r_width <= w_width2;
                        r_lo    <= '0;
                        r_state <= M_RUN;
                    end else if (w_run_end) begin
                        r_lo    <= r_hi;
                        r_state <= M_RUN;
                    end else begin
                        r_state <= M_RD;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_rd_a_addr = r_a[AW-1:0];
    assign o_rd_b_addr = r_b[AW-1:0];
    assign o_wr_en     = (r_state == M_CMP);
    assign o_wr_addr   = r_wr[AW-1:0];
    assign o_wr_data   = w_take_a ? i_rd_a_data : i_rd_b_data;

    always_comb begin
        o_stat.busy      = (r_state != M_IDLE);
        o_stat.pass_done = (r_state == M_CMP) && w_pass_end;
        o_stat.done      = (r_state == M_CMP) && w_all_done;
    end

endmodule

// ----- src/merge_sorter_unit.sv -----
// merge_sorter_unit: top level, request decode, set bookkeeping and result register
// depends on msu_pkg, msu_if, msu_store and msu_merge
//
// usage:
// - i_in carries requests: cmd load appends value to the set, cmd read returns the
//   next value in ascending order. loads beyond CAPACITY are dropped. a load after
//   any read discards the old set and starts a new one.
// - o_out carries one result per read: sorted_value, is_last on the final value,
//   status empty (value 0) when nothing is left to read.
// - a load leaves the block in S_IDLE, so the next request can follow at once.
// - a read of an already sorted set goes to S_DATA, which puts its result in the
//   output register once it is free, then returns to S_IDLE for the next request.
// - the first read after loading n values first sorts the set: ceil(log2 n) merge
//   passes between the two memories; the single compare-and-write step of the merge
//   engine reads and writes one value at a time, with a setup step before each run.
// - results sit in an output register; while the receiver stalls, loads are still
//   taken, and a read waits for the register to drain before it completes.
// - reset clears counts and flags; memory contents are not cleared and never read
//   before being written. the block is ready right after reset.

module merge_sorter_unit #(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    msu_in_if.sink   i_in,
    msu_out_if.source o_out
);

    import msu_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int NW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SORT,
        S_FETCH,
        S_DATA
    } t_state;

    t_state                r_state;
    logic [NW-1:0]         r_count;
    logic [NW-1:0]         r_read_pos;
    logic                  r_sorted;
    logic                  r_sel;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;
    logic                  r_out_last;
    logic                  r_out_status;

    logic                  w_accept, w_load, w_load_we, w_start, w_out_free, w_has_data;
    logic [AW-1:0]         w_load_addr;

    logic [AW-1:0]         m_rd_a_addr, m_rd_b_addr, m_wr_addr;
    logic                  m_wr_en;
    logic [VALUE_BITS-1:0] m_wr_data;
    t_merge_stat           m_stat;

    logic                  s_wr_en, s_wr_sel;
    logic [AW-1:0]         s_wr_addr, s_rd_a_addr;
    logic [VALUE_BITS-1:0] s_wr_data, s_rd_a_data, s_rd_b_data;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load     = w_accept && (i_in.cmd == CMD_LOAD);
    assign w_start    = w_accept && (i_in.cmd == CMD_READ) && !r_sorted &&
                        (r_count >= NW'(2));
    // a load on a sorted set restarts at entry zero
    assign w_load_addr = r_sorted ? '0 : r_count[AW-1:0];
    assign w_load_we   = w_load && (r_sorted || (r_count < NW'(CAPACITY)));
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_has_data  = (r_read_pos < r_count);

    assign s_wr_en     = w_load_we || m_wr_en;
    assign s_wr_sel    = m_wr_en ? ~r_sel : 1'b0;
    assign s_wr_addr   = m_wr_en ? m_wr_addr : w_load_addr;
    assign s_wr_data   = m_wr_en ? m_wr_data : i_in.value;
    assign s_rd_a_addr = (r_state == S_SORT) ? m_rd_a_addr : r_read_pos[AW-1:0];

    msu_store #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (s_wr_en),
        .i_wr_sel    (s_wr_sel),
        .i_wr_addr   (s_wr_addr),
        .i_wr_data   (s_wr_data),
        .i_rd_sel    (r_sel),
        .i_rd_a_addr (s_rd_a_addr),
        .i_rd_b_addr (m_rd_b_addr),
        .o_rd_a_data (s_rd_a_data),
        .o_rd_b_data (s_rd_b_data)
    );

    msu_merge #(
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW),
        .NW         (NW)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_count     (r_count),
        .i_rd_a_data (s_rd_a_data),
        .i_rd_b_data (s_rd_b_data),
        .o_rd_a_addr (m_rd_a_addr),
        .o_rd_b_addr (m_rd_b_addr),
        .o_wr_en     (m_wr_en),
        .o_wr_addr   (m_wr_addr),
        .o_wr_data   (m_wr_data),
        .o_stat      (m_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_read_pos  <= '0;
            r_sorted    <= 1'b0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // in S_DATA the register is refilled whenever it drains
            if (r_out_valid && o_out.ready && (r_state != S_DATA)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_load) begin
                        if (r_sorted) begin
                            r_count    <= NW'(1);
                            r_read_pos <= '0;
                            r_sorted   <= 1'b0;
                            r_sel      <= 1'b0;
                        end else if (r_count < NW'(CAPACITY)) begin
                            r_count <= r_count + NW'(1);
                        end
                    end else if (w_accept) begin
                        if (!r_sorted) begin
                            r_sorted   <= 1'b1;
                            r_read_pos <= '0;
                            r_state    <= w_start ? S_SORT : S_DATA;
                        end else begin
                            r_state <= S_DATA;
                        end
                    end
                end
                S_SORT: begin
                    // sorted data ends up in the memory written by the last pass
                    if (m_stat.pass_done) begin
                        r_sel <= ~r_sel;
                    end
                    if (m_stat.done) begin
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_DATA;
                end
                S_DATA: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (w_has_data) begin
                            r_out_value  <= s_rd_a_data;
                            r_out_last   <= (r_read_pos + NW'(1) == r_count);
                            r_out_status <= STAT_OK;
                            r_read_pos   <= r_read_pos + NW'(1);
                        end else begin
                            r_out_value  <= '0;
                            r_out_last   <= 1'b0;
                            r_out_status <= STAT_EMPTY;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.is_last      = r_out_last;
    assign o_out.status       = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(CAPACITY))
        else $error("set size above capacity");

    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_read_pos <= r_count)
        else $error("read position past end of set");

    a_busy_in_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_stat.busy |-> (r_state == S_SORT))
        else $error("merge engine running outside sort");

    a_merge_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_wr_en |-> (!w_load_we && (m_wr_addr < AW'(CAPACITY - 1) ||
                                    m_wr_addr == AW'(CAPACITY - 1))))
        else $error("merge write collides with a load");

    a_done_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_stat.done |=> (r_state == S_FETCH))
        else $error("sort completion not followed by fetch");

endmodule

// ----- verif/tb_merge_sorter_unit.sv -----
// tb_merge_sorter_unit: self-checking bench for the merge sorter unit, load and read
// requests checked against an in-bench sort predictor under random handshake pressure
// depends on msu_pkg, msu_if and merge_sorter_unit
`timescale 1ns / 1ps

module tb_merge_sorter_unit;
    import msu_pkg::*;

    localparam int CAP        = 256;
    localparam int VB         = 8;
    localparam int DIR_N      = 23;
    localparam int RAND_ITEMS = 427;
    localparam int MAX_SHOWN  = 10;

    typedef struct packed {
        logic [VB-1:0] value;
        logic          last;
        logic          status;
    } t_sort_res;

    typedef struct packed {
        logic          cmd;
        logic [VB-1:0] value;
        logic          fixed_exp;
        t_sort_res     res;
    } t_dir_row;

    logic clk;
    logic rst_n;

    msu_in_if  #(.VALUE_BITS(VB)) req_if ();
    msu_out_if #(.VALUE_BITS(VB)) res_if ();

    merge_sorter_unit #(
        .CAPACITY   (CAP),
        .VALUE_BITS (VB)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // predictor state: the current set, read pointer and sorted flag
    logic [VB-1:0] sorter_set [CAP];
    int            set_len;
    int            next_pos;
    bit            set_ordered;

    t_sort_res   pending_results [$];
    int unsigned req_count;
    int unsigned mismatch_cnt;

    // typed rows: empty after reset, extremes, reads past the end
    t_dir_row dir_tab [DIR_N] = '{
        '{CMD_READ, 8'h00, 1'b1, '{8'h00, 1'b0, STAT_EMPTY}},
        '{CMD_LOAD, 8'hFF, 1'b0, '{8'h00, 1'b0, STAT_OK}},
        '{CMD_LOAD, 8'h00, 1'b0, '{8'h00, 1'b0, STAT_OK}},
        '{CMD_LOAD, 8'h80, 1'b0, '{8'h00, 1'b0, STAT_OK}},
        '{CMD_READ, 8'hFF, 1'b1, '{8'h00, 1'b0, STAT_OK}},
        '{CMD_READ, 8'h00, 1'b1, '{8'h80, 1'b0, STAT_OK}},
        '{CMD_READ, 8'hAA, 1'b1, '{8'hFF, 1'b1, STAT_OK}},
        '{CMD_READ, 8'h55, 1'b1, '{8'h00, 1'b0, STAT_EMPTY}},
        '{CMD_LOAD, 8'h5A, 1'b0, '{8'h00, 1'b0, STAT_OK}},
        '{CMD_READ, 8'h00, 1'b1, '{8'h5A, 1'b1, STAT_OK}},
        '{CMD_READ, 8'h00, 1'b1, '{8'h00, 1'b0, STAT_EMPTY}},
        '{CMD_LOAD, 8'hA5, 1'b0, '{8'h00, 1'b0, STAT_OK}},
        '{CMD_LOAD, 8'h3C, 1'b0, '{8'h00, 1'b0, STAT_OK}},
        '{CMD_LOAD, 8'hA5, 1'b0, '{8'h00, 1'b0, STAT_OK}},
        '{CMD_LOAD, 8'h01, 1'b0, '{8'h00, 1'b0, STAT_OK}},
        '{CMD_READ, 8'h00, 1'b0, '{8'h00, 1'b0, STAT_OK}},
        '{CMD_READ, 8'hFF, 1'b0, '{8'h00, 1'b0, STAT_OK}},
        '{CMD_LOAD, 8'hFF, 1'b0, '{8'h00, 1'b0, STAT_OK}},
        '{CMD_LOAD, 8'h00, 1'b0, '{8'h00, 1'b0, STAT_OK}},
        '{CMD_READ, 8'h00, 1'b1, '{8'h00, 1'b0, STAT_OK}},
        '{CMD_READ, 8'h00, 1'b1, '{8'hFF, 1'b1, STAT_OK}},
        '{CMD_READ, 8'h00, 1'b1, '{8'h00, 1'b0, STAT_EMPTY}},
        '{CMD_READ, 8'hFF, 1'b1, '{8'h00, 1'b0, STAT_EMPTY}}
    };

    // ascending order of the loaded set; only values matter so any stable sort will do
    function automatic void order_set();
        int            i;
        int            j;
        logic [VB-1:0] key;
        for (i = 1; i < set_len; i++) begin
            key = sorter_set[i];
            j   = i - 1;
            while (j >= 0 && sorter_set[j] > key) begin
                sorter_set[j + 1] = sorter_set[j];
                j--;
            end
            sorter_set[j + 1] = key;
        end
    endfunction

    function automatic bit predict_request(input logic cmd, input logic [VB-1:0] v,
                                           output t_sort_res r);
        r = '0;
        if (cmd == CMD_LOAD) begin
            // any load after reading began starts a fresh set
            if (set_ordered) begin
                set_len     = 0;
                next_pos    = 0;
                set_ordered = 1'b0;
            end
            if (set_len < CAP) begin
                sorter_set[set_len] = v;
                set_len++;
            end
            return 1'b0;
        end
        if (!set_ordered) begin
            order_set();
            set_ordered = 1'b1;
            next_pos    = 0;
        end
        if (next_pos < set_len) begin
            r.value  = sorter_set[next_pos];
            r.last   = (next_pos + 1 == set_len);
            r.status = STAT_OK;
            next_pos++;
        end else begin
            r.status = STAT_EMPTY;
        end
        return 1'b1;
    endfunction

    function automatic int phase_now();
        return (req_count / 48) % 4;
    endfunction

    task automatic issue_req(input logic cmd, input logic [VB-1:0] v,
                             input logic fixed_exp, input t_sort_res fixed_res);
        t_sort_res r;
        int        gap_pct;
        gap_pct = (phase_now() == 1) ? 88 : (phase_now() == 3) ? 9 : 0;
        while ($urandom_range(99) < gap_pct) begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd   <= cmd;
        req_if.value <= v;
        do @(posedge clk); while (!req_if.ready);
        if (predict_request(cmd, v, r))
            pending_results.push_back(fixed_exp ? fixed_res : r);
        req_count++;
        @(negedge clk);
    endtask

    function automatic logic [VB-1:0] pick_value(input bit narrow);
        if (!narrow)
            return VB'($urandom);
        // clustered near both ends so duplicates are common
        return $urandom_range(1) ? VB'(8'hFF - $urandom_range(2)) : VB'($urandom_range(2));
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver stall pattern follows the same phases as the sender
    initial begin
        int stall_pct;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            stall_pct = (phase_now() == 2) ? 88 : (phase_now() == 3) ? 9 : 0;
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        t_sort_res got;
        t_sort_res want;
        if (rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.sorted_value, res_if.is_last, res_if.status};
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_SHOWN)
                    $display("unexpected result: value %02h last %0b status %0b",
                             got.value, got.last, got.status);
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value || got.last !== want.last
                        || got.status !== want.status) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_SHOWN)
                        $display("mismatch: expected value %02h last %0b status %0b,",
                                 want.value, want.last, want.status,
                                 " got value %02h last %0b status %0b",
                                 got.value, got.last, got.status);
                end
            end
        end
    end

    initial begin
        int  n;
        int  reads;
        int  kind;
        bit  narrow;
        bit  full_done;
        req_if.valid = 1'b0;
        req_if.cmd   = CMD_LOAD;
        req_if.value = '0;
        rst_n        = 1'b0;
        set_len      = 0;
        next_pos     = 0;
        set_ordered  = 1'b0;
        req_count    = 0;
        mismatch_cnt = 0;
        full_done    = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
            issue_req(dir_tab[i].cmd, dir_tab[i].value, dir_tab[i].fixed_exp, dir_tab[i].res);

        while (req_count < DIR_N + RAND_ITEMS || !full_done) begin
            kind   = $urandom_range(9);
            narrow = ($urandom_range(3) == 0);
            if (!full_done && req_count >= DIR_N + 60) begin
                // overfill so the extra loads get dropped, then drain past the end
                n         = CAP + $urandom_range(1, 3);
                reads     = CAP + 1;
                full_done = 1'b1;
            end else if (kind <= 6) begin
                n     = (kind == 6) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                reads = n + $urandom_range(0, 2);
            end else if (kind <= 8) begin
                // partial drain, maybe of nothing; after a read the next load discards the rest
                n     = $urandom_range(2, 12);
                reads = $urandom_range(0, n - 1);
            end else begin
                n     = 0;
                reads = 0;
                repeat ($urandom_range(1, 6))
                    issue_req(1'($urandom_range(1)), pick_value(narrow), 1'b0, '0);
            end
            repeat (n) issue_req(CMD_LOAD, pick_value(narrow), 1'b0, '0);
            repeat (reads) issue_req(CMD_READ, VB'($urandom), 1'b0, '0);
        end
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
